@@ src/tmc_pkg.sv @@
// Types and constants shared by the triangle marker classifier modules.
`timescale 1ns / 1ps

package tmc_pkg;

  localparam int AREA_W    = 22;
  localparam int DAREA_W   = 23;
  localparam int CFG_IDX_W = 2;
  localparam int REGION_W  = 16;

  localparam logic [AREA_W-1:0] AREA_MIN_RESET = '0;
  localparam logic [AREA_W-1:0] AREA_MAX_RESET = '1;

  // Image region bounds in pixels.
  localparam logic [REGION_W-1:0] POS_X_LO = REGION_W'(400);
  localparam logic [REGION_W-1:0] POS_X_HI = REGION_W'(600);
  localparam logic [REGION_W-1:0] NEG_X_LO = REGION_W'(0);
  localparam logic [REGION_W-1:0] NEG_X_HI = REGION_W'(200);
  localparam logic [REGION_W-1:0] Y_LO     = REGION_W'(300);

  localparam logic signed [1:0] PAN_POSITIVE = 2'sb01;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA_MIN   = 2'd0,
    CFG_AREA_MAX   = 2'd1,
    CFG_INVERT_DIR = 2'd2
  } tmc_cfg_idx_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_min;
    logic [AREA_W-1:0] area_max;
    logic              invert_direction;
  } tmc_cfg_t;

  // Flags carried from the geometry stage to the decision stage.
  typedef struct packed {
    logic valid;
    logic in_region;
    logic on_left;
    logic down_raw;
  } tmc_geom_t;

endpackage

@@ src/tmc_if.sv @@
// Channel interfaces of the triangle marker classifier.
`timescale 1ns / 1ps

interface tmc_item_if #(
  parameter int COORD_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vertex0_x;
  logic [COORD_BITS-1:0] vertex0_y;
  logic [COORD_BITS-1:0] vertex1_x;
  logic [COORD_BITS-1:0] vertex1_y;
  logic [COORD_BITS-1:0] vertex2_x;
  logic [COORD_BITS-1:0] vertex2_y;
  logic signed [1:0]     pan_sign;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
           pan_sign,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
           pan_sign,
    output ready
  );
endinterface

interface tmc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic                           on_left;
  logic                           points_down;
  logic                           stop_scan;
  logic [tmc_pkg::DAREA_W-1:0]    doubled_area;

  modport source (
    output valid, accepted, on_left, points_down, stop_scan, doubled_area,
    input  ready
  );
  modport sink (
    input  valid, accepted, on_left, points_down, stop_scan, doubled_area,
    output ready
  );
endinterface

interface tmc_cfg_if;
  logic                         valid;
  logic                         ready;
  tmc_pkg::tmc_cfg_idx_t        index;
  logic [tmc_pkg::AREA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/triangle_marker_classifier_top.sv @@
// Top level of the triangle marker classifier.
//
// Channels: item (sink) carries one candidate triangle, three pixel vertices
// and the pan sign; result (source) returns one classification per triangle;
// cfg (sink) writes area_min (index 0), area_max (index 1) and
// invert_direction (index 2). Each transfer happens on a clock edge with
// valid and ready both high; cfg is always ready.
// The block is a three-register pipeline: input register, geometry register
// (determinant, region and direction), then the result register. Each item
// moves through these registers in order, and one item per cycle
// is sustained while the receiver keeps ready high, because each stage is a
// single register that moves on in the same cycle as the stage after it.
// When the receiver stalls, each stage still takes an item while the stage
// after it is empty, so up to three triangles are held before item.ready
// drops. Synchronous reset empties every stage, clears the acceptance count
// and restores the register defaults (area limits fully open, no inversion).
// Write configuration only while no triangle is in flight.
`timescale 1ns / 1ps

module triangle_marker_classifier_top #(
  parameter int COORD_BITS = 11
) (
  input  logic          clk,
  input  logic          rst,
  tmc_item_if.sink      item,
  tmc_result_if.source  result,
  tmc_cfg_if.sink       cfg
);

  logic                  s1_valid;
  logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [1:0]     pan_sign;
  logic                  geom_take, dec_take;
  tmc_pkg::tmc_cfg_t     cfg_regs;
  tmc_pkg::tmc_geom_t    geom;
  logic signed [2*COORD_BITS+2:0] det;

  assign cfg.ready  = 1'b1;
  assign item.ready = !s1_valid || geom_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.area_min         <= tmc_pkg::AREA_MIN_RESET;
      cfg_regs.area_max         <= tmc_pkg::AREA_MAX_RESET;
      cfg_regs.invert_direction <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tmc_pkg::CFG_AREA_MIN:   cfg_regs.area_min <= cfg.data;
        tmc_pkg::CFG_AREA_MAX:   cfg_regs.area_max <= cfg.data;
        tmc_pkg::CFG_INVERT_DIR: cfg_regs.invert_direction <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
      if (item.valid) begin
        x0       <= item.vertex0_x;
        y0       <= item.vertex0_y;
        x1       <= item.vertex1_x;
        y1       <= item.vertex1_y;
        x2       <= item.vertex2_x;
        y2       <= item.vertex2_y;
        pan_sign <= item.pan_sign;
      end
    end
  end

  tmc_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .take      (geom_take),
    .x0        (x0),
    .y0        (y0),
    .x1        (x1),
    .y1        (y1),
    .x2        (x2),
    .y2        (y2),
    .pan_sign  (pan_sign),
    .down_take (dec_take),
    .geom      (geom),
    .det       (det)
  );

  tmc_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .geom     (geom),
    .det      (det),
    .take     (dec_take),
    .result   (result)
  );

endmodule

@@ src/tmc_geom.sv @@
// Geometry stage: shoelace determinant, region test and arrow direction.
`timescale 1ns / 1ps

module tmc_geom #(
  parameter int COORD_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                take,
  input  logic [COORD_BITS-1:0]               x0,
  input  logic [COORD_BITS-1:0]               y0,
  input  logic [COORD_BITS-1:0]               x1,
  input  logic [COORD_BITS-1:0]               y1,
  input  logic [COORD_BITS-1:0]               x2,
  input  logic [COORD_BITS-1:0]               y2,
  input  logic signed [1:0]                   pan_sign,
  input  logic                                down_take,
  output tmc_pkg::tmc_geom_t                  geom,
  output logic signed [2*COORD_BITS+2:0]      det
);

  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int DETW = PW + 1;
  localparam int RW   = tmc_pkg::REGION_W;

  logic signed [COORD_BITS:0] dy12, dy20, dy01;
  logic signed [PW-1:0]       p0, p1, p2;
  logic signed [DETW-1:0]     det_next;
  logic                       pos, neg;
  logic [RW-1:0]              ex0, ex1, ex2, ey0, ey1, ey2;
  logic                       x_ok0, x_ok1, x_ok2, y_ok, region_next;
  logic [COORD_BITS-1:0]      ymin01, ymax01, ymin, ymax;
  logic [COORD_BITS:0]        ysum;
  logic                       n0, n1, n2, exactly_one;
  tmc_pkg::tmc_geom_t         geom_next;

  assign take = !geom.valid || down_take;

  // Shoelace determinant; each product is one narrow signed multiply.
  assign dy12 = $signed({1'b0, y1}) - $signed({1'b0, y2});
  assign dy20 = $signed({1'b0, y2}) - $signed({1'b0, y0});
  assign dy01 = $signed({1'b0, y0}) - $signed({1'b0, y1});
  assign p0   = $signed({1'b0, x0}) * dy12;
  assign p1   = $signed({1'b0, x1}) * dy20;
  assign p2   = $signed({1'b0, x2}) * dy01;
  assign det_next = DETW'(p0) + DETW'(p1) + DETW'(p2);

  // A pan pattern with the sign bit set counts as negative.
  assign pos = (pan_sign == tmc_pkg::PAN_POSITIVE);
  assign neg = pan_sign[1];

  assign ex0 = RW'(x0);
  assign ex1 = RW'(x1);
  assign ex2 = RW'(x2);
  assign ey0 = RW'(y0);
  assign ey1 = RW'(y1);
  assign ey2 = RW'(y2);

  always_comb begin
    x_ok0 = 1'b1;
    x_ok1 = 1'b1;
    x_ok2 = 1'b1;
    if (pos) begin
      x_ok0 = (ex0 > tmc_pkg::POS_X_LO) && (ex0 < tmc_pkg::POS_X_HI);
      x_ok1 = (ex1 > tmc_pkg::POS_X_LO) && (ex1 < tmc_pkg::POS_X_HI);
      x_ok2 = (ex2 > tmc_pkg::POS_X_LO) && (ex2 < tmc_pkg::POS_X_HI);
    end else if (neg) begin
      x_ok0 = (ex0 > tmc_pkg::NEG_X_LO) && (ex0 < tmc_pkg::NEG_X_HI);
      x_ok1 = (ex1 > tmc_pkg::NEG_X_LO) && (ex1 < tmc_pkg::NEG_X_HI);
      x_ok2 = (ex2 > tmc_pkg::NEG_X_LO) && (ex2 < tmc_pkg::NEG_X_HI);
    end
  end

  assign y_ok = (ey0 >= tmc_pkg::Y_LO) && (ey1 >= tmc_pkg::Y_LO) && (ey2 >= tmc_pkg::Y_LO);
  assign region_next = x_ok0 && x_ok1 && x_ok2 && y_ok;

  assign ymin01 = (y1 < y0) ? y1 : y0;
  assign ymax01 = (y1 > y0) ? y1 : y0;
  assign ymin   = (y2 < ymin01) ? y2 : ymin01;
  assign ymax   = (y2 > ymax01) ? y2 : ymax01;
  assign ysum   = (COORD_BITS + 1)'(ymin) + (COORD_BITS + 1)'(ymax);

  // A vertex is near the top when ymax - y >= y - ymin, i.e. 2y <= ymin + ymax.
  assign n0 = ({y0, 1'b0} <= ysum);
  assign n1 = ({y1, 1'b0} <= ysum);
  assign n2 = ({y2, 1'b0} <= ysum);
  assign exactly_one = (n0 & ~n1 & ~n2) | (~n0 & n1 & ~n2) | (~n0 & ~n1 & n2);

  always_comb begin
    geom_next           = geom;
    geom_next.valid     = in_valid;
    if (in_valid) begin
      geom_next.in_region = region_next;
      geom_next.on_left   = pos;
      geom_next.down_raw  = !exactly_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom <= '0;
    end else if (take) begin
      geom <= geom_next;
      if (in_valid) begin
        det <= det_next;
      end
    end
  end

endmodule

@@ src/tmc_decide.sv @@
// Decision stage: area limits, acceptance count and the result register.
`timescale 1ns / 1ps

module tmc_decide #(
  parameter int COORD_BITS = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tmc_pkg::tmc_cfg_t               cfg_regs,
  input  tmc_pkg::tmc_geom_t              geom,
  input  logic signed [2*COORD_BITS+2:0]  det,
  output logic                            take,
  tmc_result_if.source                    result
);

  localparam int DETW = 2 * COORD_BITS + 3;
  localparam int DW   = (DETW > tmc_pkg::DAREA_W) ? DETW : tmc_pkg::DAREA_W;

  logic [DETW-1:0] mag;
  logic [DW-1:0]   d2, lim_lo, lim_hi;
  logic            area_ok, acc_now;
  logic [1:0]      accept_count;

  assign take = !result.valid || result.ready;

  assign mag    = det[DETW-1] ? DETW'(-det) : DETW'(det);
  assign d2     = DW'(mag);
  assign lim_lo = DW'({cfg_regs.area_min, 1'b0});
  assign lim_hi = DW'({cfg_regs.area_max, 1'b0});
  assign area_ok = (lim_lo <= d2) && (d2 <= lim_hi);
  assign acc_now = area_ok && geom.in_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      accept_count <= 2'd0;
    end else if (take) begin
      result.valid <= geom.valid;
      if (geom.valid) begin
        result.accepted     <= acc_now;
        result.on_left      <= geom.on_left;
        result.points_down  <= geom.down_raw ^ cfg_regs.invert_direction;
        result.stop_scan    <= acc_now && (accept_count != 2'd0);
        result.doubled_area <= d2[tmc_pkg::DAREA_W-1:0];
        if (acc_now && accept_count != 2'd3) begin
          accept_count <= accept_count + 2'd1;
        end
      end
    end
  end

  a_stop_needs_accept: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.stop_scan |-> result.accepted)
    else $error("stop_scan raised on a rejected triangle");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> accept_count >= $past(accept_count))
    else $error("acceptance count went down");

  a_accept_reaches_output: assert property (@(posedge clk) disable iff (rst)
    take && geom.valid && acc_now |=> result.valid && result.accepted)
    else $error("accepted triangle lost on its way to the result register");

  a_second_accept_stops: assert property (@(posedge clk) disable iff (rst)
    take && geom.valid && acc_now && accept_count != 2'd0 |=> result.stop_scan)
    else $error("second acceptance did not raise stop_scan");

endmodule

@@ bench/marker_result_checker.sv @@
// Checker that predicts each triangle classification and compares it with the block's output.
`timescale 1ns / 1ps

module marker_result_checker #(
  parameter int COORD_BITS = 11
) (
  input  logic  clk,
  input  logic  rst,
  tmc_item_if   item,
  tmc_result_if result,
  tmc_cfg_if    cfg,
  output int    mismatches,
  output int    pending
);

  typedef struct packed {
    logic                        accepted;
    logic                        on_left;
    logic                        points_down;
    logic                        stop_scan;
    logic [tmc_pkg::DAREA_W-1:0] doubled_area;
  } marker_result_t;

  logic [tmc_pkg::AREA_W-1:0] lim_min;
  logic [tmc_pkg::AREA_W-1:0] lim_max;
  logic                       invert;
  logic [1:0]                 accepts_seen;
  int                         results_seen;
  marker_result_t             expected_results[$];

  task automatic flag_mismatch(input string what);
    $display("triangle result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Stop flag is left clear here; it depends on the running acceptance count.
  function automatic marker_result_t classify_triangle(
    input logic [2:0][COORD_BITS-1:0] xs,
    input logic [2:0][COORD_BITS-1:0] ys,
    input logic [1:0]                 pan
  );
    int             x[3];
    int             y[3];
    int             det;
    int             mag;
    int             ylo;
    int             yhi;
    int             near_top;
    logic           pos;
    logic           neg;
    logic           in_region;
    logic           area_ok;
    marker_result_t r;
    pos = (pan == tmc_pkg::PAN_POSITIVE);
    neg = pan[1];
    for (int k = 0; k < 3; k++) begin
      x[k] = int'(xs[k]);
      y[k] = int'(ys[k]);
    end
    det = x[0] * (y[1] - y[2]) + x[1] * (y[2] - y[0]) + x[2] * (y[0] - y[1]);
    mag = (det < 0) ? -det : det;
    area_ok = (2 * int'(lim_min) <= mag) && (mag <= 2 * int'(lim_max));
    in_region = 1'b1;
    ylo = y[0];
    yhi = y[0];
    for (int k = 0; k < 3; k++) begin
      if (pos && !(x[k] > int'(tmc_pkg::POS_X_LO) && x[k] < int'(tmc_pkg::POS_X_HI)))
        in_region = 1'b0;
      if (neg && !(x[k] > int'(tmc_pkg::NEG_X_LO) && x[k] < int'(tmc_pkg::NEG_X_HI)))
        in_region = 1'b0;
      if (y[k] < int'(tmc_pkg::Y_LO)) in_region = 1'b0;
      if (y[k] < ylo) ylo = y[k];
      if (y[k] > yhi) yhi = y[k];
    end
    // A vertex exactly halfway between the extremes counts towards the top row.
    near_top = 0;
    for (int k = 0; k < 3; k++) begin
      if ((yhi - y[k]) >= (y[k] - ylo)) near_top++;
    end
    r.accepted     = area_ok && in_region;
    r.on_left      = pos;
    r.points_down  = (near_top != 1) ^ invert;
    r.stop_scan    = 1'b0;
    r.doubled_area = tmc_pkg::DAREA_W'(mag);
    return r;
  endfunction

  always @(posedge clk) begin : track
    marker_result_t want;
    if (rst) begin
      lim_min      <= tmc_pkg::AREA_MIN_RESET;
      lim_max      <= tmc_pkg::AREA_MAX_RESET;
      invert       <= 1'b0;
      accepts_seen <= '0;
      pending      <= 0;
      mismatches    = 0;
      results_seen  = 0;
      expected_results.delete();
    end else begin
      // The result of an earlier triangle is retired before this cycle's triangle is queued.
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result transfer with no triangle outstanding");
        end else begin
          want = expected_results.pop_front();
          if (result.accepted !== want.accepted)
            flag_mismatch($sformatf("accepted %b, expected %b",
                                    result.accepted, want.accepted));
          if (result.on_left !== want.on_left)
            flag_mismatch($sformatf("on_left %b, expected %b",
                                    result.on_left, want.on_left));
          if (result.points_down !== want.points_down)
            flag_mismatch($sformatf("points_down %b, expected %b",
                                    result.points_down, want.points_down));
          if (result.stop_scan !== want.stop_scan)
            flag_mismatch($sformatf("stop_scan %b, expected %b",
                                    result.stop_scan, want.stop_scan));
          if (result.doubled_area !== want.doubled_area)
            flag_mismatch($sformatf("doubled_area %0d, expected %0d",
                                    result.doubled_area, want.doubled_area));
        end
        results_seen++;
      end
      if (item.valid && item.ready) begin
        want = classify_triangle({item.vertex2_x, item.vertex1_x, item.vertex0_x},
                                 {item.vertex2_y, item.vertex1_y, item.vertex0_y},
                                 item.pan_sign);
        if (want.accepted) begin
          want.stop_scan = (accepts_seen != 2'd0);
          if (accepts_seen != 2'd3) accepts_seen <= accepts_seen + 2'd1;
        end
        expected_results.push_back(want);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          tmc_pkg::CFG_AREA_MIN: begin
            lim_min <= cfg.data;
          end
          tmc_pkg::CFG_AREA_MAX: begin
            lim_max <= cfg.data;
          end
          tmc_pkg::CFG_INVERT_DIR: begin
            invert <= cfg.data[0];
          end
          default: begin
          end
        endcase
      end
      pending <= expected_results.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: clock, reset, triangle stimulus, receiver back-pressure and the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int COORD_BITS    = 11;
  localparam int RUN_LIMIT     = 200000;
  localparam int PHASE_ITEMS   = 100;
  localparam int PHASE_COUNT   = 7;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] xs;
    logic [2:0][COORD_BITS-1:0] ys;
    logic [1:0]                 pan;
  } triangle_t;

  logic clk;
  logic rst;
  logic steady;
  int   hold_requests;
  int   mismatches;
  int   pending;
  int   cycles = 0;

  tmc_item_if #(.COORD_BITS(COORD_BITS)) item_ch ();
  tmc_result_if                          result_ch ();
  tmc_cfg_if                             cfg_ch ();

  triangle_marker_classifier_top #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  marker_result_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("** triangle_marker_classifier_top: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int served;
    served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ch.ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  function automatic triangle_t triangle_at(input int x0, y0, x1, y1, x2, y2,
                                            input logic [1:0] pan);
    triangle_t t;
    t.xs  = {COORD_BITS'(x2), COORD_BITS'(x1), COORD_BITS'(x0)};
    t.ys  = {COORD_BITS'(y2), COORD_BITS'(y1), COORD_BITS'(y0)};
    t.pan = pan;
    return t;
  endfunction

  // Mostly triangles inside the region for their side, some on its edges, some flat,
  // and the rest arbitrary bit patterns.
  function automatic triangle_t random_triangle();
    triangle_t t;
    int        mode;
    int        lo;
    int        hi;
    mode  = $urandom_range(99);
    t.pan = 2'($urandom_range(3));
    if (t.pan == tmc_pkg::PAN_POSITIVE) begin
      lo = 401;
      hi = 599;
    end else if (t.pan[1]) begin
      lo = 1;
      hi = 199;
    end else begin
      lo = 0;
      hi = 2047;
    end
    for (int k = 0; k < 3; k++) begin
      if (mode < 60) begin
        t.xs[k] = COORD_BITS'($urandom_range(hi, lo));
        t.ys[k] = COORD_BITS'($urandom_range(700, 300));
      end else if (mode < 80) begin
        t.xs[k] = COORD_BITS'($urandom_range(1) ? lo - int'($urandom_range(1))
                                                : hi + int'($urandom_range(1)));
        t.ys[k] = COORD_BITS'(299 + $urandom_range(2));
      end else begin
        t.xs[k] = COORD_BITS'($urandom);
        t.ys[k] = COORD_BITS'($urandom);
      end
    end
    if (mode >= 50 && mode < 60) begin
      t.ys[1] = t.ys[0];
      t.ys[2] = t.ys[0];
    end
    return t;
  endfunction

  task automatic offer_triangle(input triangle_t t);
    item_ch.valid     <= 1'b1;
    item_ch.vertex0_x <= t.xs[0];
    item_ch.vertex0_y <= t.ys[0];
    item_ch.vertex1_x <= t.xs[1];
    item_ch.vertex1_y <= t.ys[1];
    item_ch.vertex2_x <= t.xs[2];
    item_ch.vertex2_y <= t.ys[2];
    item_ch.pan_sign  <= t.pan;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int gap);
    item_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic await_drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input tmc_pkg::tmc_cfg_idx_t idx,
                           input logic [tmc_pkg::AREA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_limits(input logic [tmc_pkg::AREA_W-1:0] lo, hi, input logic inv);
    write_reg(tmc_pkg::CFG_AREA_MIN, lo);
    write_reg(tmc_pkg::CFG_AREA_MAX, hi);
    write_reg(tmc_pkg::CFG_INVERT_DIR, tmc_pkg::AREA_W'(inv));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int  lo;
    logic calm;
    rst               <= 1'b1;
    steady            <= 1'b0;
    hold_requests     <= 0;
    item_ch.valid     <= 1'b0;
    item_ch.vertex0_x <= '0;
    item_ch.vertex0_y <= '0;
    item_ch.vertex1_x <= '0;
    item_ch.vertex1_y <= '0;
    item_ch.vertex2_x <= '0;
    item_ch.vertex2_y <= '0;
    item_ch.pan_sign  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= tmc_pkg::CFG_AREA_MIN;
    cfg_ch.data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limits: fully open area window, no inversion.
    offer_triangle(triangle_at(450, 400, 500, 400, 550, 400, 2'b01));   // flat, all level
    offer_triangle(triangle_at(401, 300, 599, 300, 500, 2047, 2'b01));
    offer_triangle(triangle_at(400, 300, 500, 300, 500, 400, 2'b01));
    offer_triangle(triangle_at(450, 300, 600, 300, 500, 400, 2'b01));
    offer_triangle(triangle_at(1, 300, 199, 300, 100, 500, 2'b11));
    offer_triangle(triangle_at(0, 300, 100, 300, 100, 500, 2'b11));
    offer_triangle(triangle_at(50, 300, 200, 350, 100, 500, 2'b11));
    offer_triangle(triangle_at(10, 310, 150, 320, 100, 600, 2'b10));
    offer_triangle(triangle_at(0, 300, 2047, 300, 1000, 2047, 2'b00));
    offer_triangle(triangle_at(500, 299, 550, 400, 450, 400, 2'b01));
    offer_triangle(triangle_at(0, 0, 2047, 0, 0, 2047, 2'b00));
    offer_triangle(triangle_at(2047, 2047, 2047, 2047, 2047, 2047, 2'b10));
    offer_triangle(triangle_at(0, 2047, 2047, 2047, 2047, 0, 2'b00));
    offer_triangle(triangle_at(450, 300, 500, 500, 550, 500, 2'b01));
    offer_triangle(triangle_at(450, 300, 500, 400, 550, 500, 2'b01));   // middle vertex tied
    offer_triangle(triangle_at(420, 900, 580, 900, 500, 700, 2'b01));
    offer_triangle(triangle_at(0, 300, 2047, 301, 1024, 2047, 2'b00));

    // Narrow area window, checked on both sides of each bound.
    await_drain();
    program_limits(tmc_pkg::AREA_W'(1000), tmc_pkg::AREA_W'(2000), 1'b1);
    offer_triangle(triangle_at(0, 300, 1999, 300, 0, 301, 2'b00));
    offer_triangle(triangle_at(0, 300, 2000, 300, 0, 301, 2'b00));
    offer_triangle(triangle_at(0, 300, 2001, 301, 2, 302, 2'b00));
    offer_triangle(triangle_at(0, 300, 2001, 301, 1, 302, 2'b00));
    offer_triangle(triangle_at(450, 300, 500, 500, 550, 500, 2'b01));

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      await_drain();
      case (phase)
        0: program_limits('0, '1, 1'b1);
        1: program_limits('1, '0, 1'b0);
        2: program_limits('1, '1, 1'b1);
        3: program_limits('0, '0, 1'b0);
        default: begin
          lo = $urandom_range(20000);
          program_limits(tmc_pkg::AREA_W'(lo),
                         tmc_pkg::AREA_W'(lo + $urandom_range(30000)),
                         1'($urandom_range(1)));
        end
      endcase
      calm = (phase == 4);
      steady <= calm;
      // The first phase starts with the receiver held off, so the pipeline fills and stalls.
      if (phase == 0) hold_requests <= hold_requests + 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (!calm && $urandom_range(99) < 14) pause_sender(1);
        offer_triangle(random_triangle());
      end
    end

    await_drain();
    if (mismatches == 0) begin
      $display("** triangle_marker_classifier_top: PASSED **");
    end else begin
      $display("** triangle_marker_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule
